[sv/afal_pkg.sv]
// Shared types and constants for the lifetime aliasing pool allocator.
// Used by afal_ctrl and the top level; has no dependencies.
`default_nettype none

package afal_pkg;

    // Marks a request whose resource is never used.
    localparam logic [31:0] UNUSED_PASS = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_REUSED   = 2'd0,
        STATUS_NEW      = 2'd1,
        STATUS_IMPORTED = 2'd2,
        STATUS_FULL     = 2'd3
    } afal_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } afal_state_t;

    typedef struct packed {
        logic [15:0]  handle;
        afal_status_t status;
        logic [3:0]   slot;
        logic         is_image;
    } afal_result_t;

endpackage

`default_nettype wire

[sv/afal_pool_mem.sv]
// Slot storage for both pools: descriptor keys and last-use passes.
// One write port, one read port with registered read data. No dependencies.
`default_nettype none

module afal_pool_mem #(
    parameter int AW = 5,
    parameter int KW = 32
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [KW-1:0] rd_key,
    output logic      [31:0]   rd_last,
    input  wire logic          wr_key_en,
    input  wire logic          wr_last_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [KW-1:0] wr_key,
    input  wire logic [31:0]   wr_last
);

    localparam int DEPTH = 1 << AW;

    logic [KW-1:0] key_mem  [DEPTH];
    logic [31:0]   last_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_last_en) begin
            last_mem[wr_addr] <= wr_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key  <= key_mem[rd_addr];
            rd_last <= last_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/afal_ctrl.sv]
// Request sequencer: first-fit scan over the selected pool, then write-back.
// Depends on afal_pkg and afal_pool_mem.
`default_nettype none

module afal_ctrl #(
    parameter int POOL_DEPTH = 16,
    parameter int KEY_BITS   = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic [15:0]           req_handle,
    input  wire logic                  req_is_image,
    input  wire logic                  req_is_imported,
    input  wire logic [31:0]           req_desc_key,
    input  wire logic [31:0]           req_first_pass,
    input  wire logic [31:0]           req_last_pass,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output afal_pkg::afal_result_t     res
);

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int AW = IW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

    afal_pkg::afal_state_t  state_reg, state_next;
    afal_pkg::afal_status_t status_reg, status_next;

    logic [15:0]   handle_reg;
    logic          img_reg;
    logic [KW-1:0] key_reg;
    logic [31:0]   first_reg;
    logic [31:0]   last_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_img_reg, cnt_img_next;
    logic [CW-1:0] cnt_buf_reg, cnt_buf_next;

    logic          accept;
    logic          rd_en;
    logic [KW-1:0] rd_key;
    logic [31:0]   rd_last;
    logic          match;
    logic          wr_key_en;
    logic          wr_last_en;

    afal_pool_mem #(
        .AW (AW),
        .KW (KW)
    ) u_mem (
        .aclk       (aclk),
        .rd_en      (rd_en),
        .rd_addr    ({img_reg, issue_reg[IW-1:0]}),
        .rd_key     (rd_key),
        .rd_last    (rd_last),
        .wr_key_en  (wr_key_en),
        .wr_last_en (wr_last_en),
        .wr_addr    ({img_reg, idx_reg}),
        .wr_key     (key_reg),
        .wr_last    (last_reg)
    );

    assign accept = req_valid && req_ready;
    assign rd_en  = (state_reg == afal_pkg::ST_SCAN) && (issue_reg < n_reg);
    assign match  = chk_valid_reg && (rd_key == key_reg) && (rd_last < first_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= afal_pkg::ST_IDLE;
            chk_valid_reg <= 1'b0;
            cnt_img_reg   <= '0;
            cnt_buf_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            cnt_img_reg   <= cnt_img_next;
            cnt_buf_reg   <= cnt_buf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            handle_reg <= req_handle;
            img_reg    <= req_is_image;
            key_reg    <= req_desc_key[KW-1:0];
            first_reg  <= req_first_pass;
            last_reg   <= req_last_pass;
        end
        n_reg       <= n_next;
        issue_reg   <= issue_next;
        chk_idx_reg <= chk_idx_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
    end

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        idx_next       = idx_reg;
        cnt_img_next   = cnt_img_reg;
        cnt_buf_next   = cnt_buf_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        wr_key_en      = 1'b0;
        wr_last_en     = 1'b0;

        case (state_reg)
            afal_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid && (req_first_pass != afal_pkg::UNUSED_PASS)) begin
                    issue_next = '0;
                    n_next     = req_is_image ? cnt_img_reg : cnt_buf_reg;
                    if (req_is_imported) begin
                        status_next = afal_pkg::STATUS_IMPORTED;
                        idx_next    = '0;
                        state_next  = afal_pkg::ST_FINISH;
                    end else begin
                        state_next = afal_pkg::ST_SCAN;
                    end
                end
            end
            afal_pkg::ST_SCAN: begin
                // One read is issued per cycle; its data is compared in the next.
                chk_valid_next = rd_en;
                chk_idx_next   = issue_reg[IW-1:0];
                issue_next     = rd_en ? issue_reg + CW'(1) : issue_reg;
                if (match) begin
                    chk_valid_next = 1'b0;
                    status_next    = afal_pkg::STATUS_REUSED;
                    idx_next       = chk_idx_reg;
                    state_next     = afal_pkg::ST_FINISH;
                end else if (!rd_en) begin
                    state_next = afal_pkg::ST_FINISH;
                    if (n_reg < DEPTH_C) begin
                        status_next = afal_pkg::STATUS_NEW;
                        idx_next    = n_reg[IW-1:0];
                    end else begin
                        status_next = afal_pkg::STATUS_FULL;
                        idx_next    = '0;
                    end
                end
            end
            afal_pkg::ST_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = afal_pkg::ST_IDLE;
                    wr_last_en = (status_reg == afal_pkg::STATUS_REUSED) ||
                                 (status_reg == afal_pkg::STATUS_NEW);
                    wr_key_en  = (status_reg == afal_pkg::STATUS_NEW);
                    if (status_reg == afal_pkg::STATUS_NEW) begin
                        if (img_reg) begin
                            cnt_img_next = cnt_img_reg + CW'(1);
                        end else begin
                            cnt_buf_next = cnt_buf_reg + CW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = afal_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.handle   = handle_reg;
    assign res.status   = status_reg;
    assign res.slot     = 4'(idx_reg);
    assign res.is_image = img_reg;

endmodule

`default_nettype wire

[sv/lifetime_aliasing_pool_allocator.sv]
// Top level of the lifetime aliasing pool allocator: stream ports and result register.
// Depends on afal_pkg and afal_ctrl.
//
//  channel | direction | tdata                                   | tuser
//  s_      | in        | handle, desc_key, first_pass, last_pass | is_image, is_imported
//  m_      | out       | handle_out, status, slot (zero padded)  | is_image_out
//
// A request runs in order: the accept in idle, reads of the single slot memory port
// over the n slots held in its pool (up to POOL_DEPTH), each read's data compared
// with the request, then a finish step that writes the slot back once the result is
// taken. A hit ends the scan early. Unused requests are taken in idle and start no
// work and give no result; imported requests skip the scan.
// Reset empties both pools; no clearing pass is needed.
// A result waits in the output register while the next word is taken in.
`default_nettype none

module lifetime_aliasing_pool_allocator #(
    parameter int POOL_DEPTH = 16,
    parameter int KEY_BITS   = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] handle, [47:16] desc_key, [79:48] first_pass, [111:80] last_pass
    input  wire logic [111:0] s_tdata,
    // [0] is_image, [1] is_imported
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [15:0] handle_out, [17:16] status, [21:18] slot, [23:22] zero
    output logic [23:0]       m_tdata,
    // [0] is_image_out
    output logic              m_tuser
);

    logic                   res_valid;
    logic                   res_ready;
    afal_pkg::afal_result_t res;
    afal_pkg::afal_result_t out_reg;
    logic                   out_valid_reg;

    afal_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .KEY_BITS   (KEY_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_handle      (s_tdata[15:0]),
        .req_is_image    (s_tuser[0]),
        .req_is_imported (s_tuser[1]),
        .req_desc_key    (s_tdata[47:16]),
        .req_first_pass  (s_tdata[79:48]),
        .req_last_pass   (s_tdata[111:80]),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.slot, out_reg.status, out_reg.handle};
    assign m_tuser  = out_reg.is_image;

    // Imported and full answers never name a slot.
    a_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:16] == afal_pkg::STATUS_IMPORTED ||
                     m_tdata[17:16] == afal_pkg::STATUS_FULL) |-> m_tdata[21:18] == 4'd0)
        else $error("imported or full result carries a nonzero slot");

    // An unused request leaves the block free for the next word.
    a_unused_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[79:48] == afal_pkg::UNUSED_PASS |=> s_tready)
        else $error("unused request started work");

    // A new result only appears after a request was in progress.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for lifetime_aliasing_pool_allocator: streams sorted and noisy
// requests and checks every result word against a first-fit model of both pools.
// Depends on afal_pkg and the allocator RTL only.

module tb;

    localparam int POOL_SLOTS  = 16;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int PHASE_ITEMS = 470;

    typedef struct {
        logic [15:0] handle;
        logic        is_image;
        logic        is_imported;
        logic [31:0] key;
        logic [31:0] first;
        logic [31:0] last;
    } request_t;

    // Mirrors both pools and holds the answers still owed by the block.
    class pool_scoreboard;
        logic [31:0]            slot_key [2][POOL_SLOTS];
        logic [31:0]            slot_last [2][POOL_SLOTS];
        int unsigned            used [2];
        afal_pkg::afal_result_t owed [$];
        int unsigned            failures;
        int unsigned            requests;
        int unsigned            answered;
        int unsigned            by_status [4];

        function new();
            used      = '{0, 0};
            failures  = 0;
            requests  = 0;
            answered  = 0;
            by_status = '{0, 0, 0, 0};
        endfunction

        function void note_request(request_t r);
            afal_pkg::afal_result_t res;
            int unsigned            k;
            int unsigned            i;
            bit                     hit;
            requests++;
            if (r.first == afal_pkg::UNUSED_PASS) return;
            res.handle   = r.handle;
            res.is_image = r.is_image;
            res.slot     = '0;
            if (r.is_imported) begin
                res.status = afal_pkg::STATUS_IMPORTED;
            end else begin
                k   = r.is_image;
                hit = 0;
                // First fit: lowest slot with the same key whose lifetime ended earlier.
                for (i = 0; i < used[k] && !hit; i++) begin
                    if (slot_key[k][i] == r.key && slot_last[k][i] < r.first) begin
                        slot_last[k][i] = r.last;
                        res.status      = afal_pkg::STATUS_REUSED;
                        res.slot        = 4'(i);
                        hit             = 1;
                    end
                end
                if (!hit && used[k] < POOL_SLOTS) begin
                    slot_key[k][used[k]]  = r.key;
                    slot_last[k][used[k]] = r.last;
                    res.status            = afal_pkg::STATUS_NEW;
                    res.slot              = 4'(used[k]);
                    used[k]++;
                end else if (!hit) begin
                    res.status = afal_pkg::STATUS_FULL;
                end
            end
            by_status[res.status]++;
            owed.insert(owed.size(), res);
        endfunction

        function void report(string what, afal_pkg::afal_result_t want,
                             afal_pkg::afal_result_t got);
            if (failures < 10) begin
                $display("%0t: %s: expected handle %h status %0d slot %0d image %0d",
                         $realtime, what, want.handle, want.status, want.slot,
                         want.is_image);
                $display("%0t: %s: got      handle %h status %0d slot %0d image %0d",
                         $realtime, what, got.handle, got.status, got.slot,
                         got.is_image);
            end
            failures++;
        endfunction

        function void check_result(logic [23:0] word, logic flag);
            afal_pkg::afal_result_t want;
            afal_pkg::afal_result_t got;
            answered++;
            got.handle   = word[15:0];
            got.status   = afal_pkg::afal_status_t'(word[17:16]);
            got.slot     = word[21:18];
            got.is_image = flag;
            if (owed.size() == 0) begin
                want = '0;
                report("unexpected word", want, got);
                return;
            end
            want = owed.pop_front();
            if (got.handle !== want.handle || got.status !== want.status ||
                got.slot !== want.slot || got.is_image !== want.is_image)
                report("mismatch", want, got);
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         m_tuser;

    pool_scoreboard sb;
    int unsigned    send_idle_pct = 0;
    int unsigned    stall_pct     = 0;
    bit             hold_request  = 0;
    int unsigned    hold_left     = 0;
    int unsigned    cycle_count   = 0;
    logic [31:0]    pass_clock    = 32'd20;

    lifetime_aliasing_pool_allocator #(
        .POOL_DEPTH(POOL_SLOTS),
        .KEY_BITS  (32)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycle_count, sb.owed.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result side: check each accepted word, then choose tready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (hold_request) begin
            hold_left    = 300;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [31:0] pool_key(bit image, int unsigned j);
        if (image) begin
            if (j == 0) return 32'h0000_0000;
            if (j == 1) return 32'hFFFF_FFFF;
            return 32'h1000_0000 | j;
        end
        return 32'h2000_0000 | j;
    endfunction

    task automatic send_word(request_t r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.last, r.first, r.key, r.handle};
        s_tuser  <= {r.is_imported, r.is_image};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic offer(logic [15:0] handle, bit image, bit imported, logic [31:0] key,
                         logic [31:0] first, logic [31:0] last);
        request_t r;
        r.handle      = handle;
        r.is_image    = image;
        r.is_imported = imported;
        r.key         = key;
        r.first       = first;
        r.last        = last;
        send_word(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (POOL_SLOTS + 4) @(posedge aclk);
    endtask

    // Mostly sorted lifetimes over a small key set, so slots really get reused;
    // the rest are unused, imported, out-of-order and full-range noise words.
    function automatic request_t random_request();
        request_t    r;
        int unsigned roll;
        r.handle      = 16'($urandom);
        r.is_image    = 1'($urandom_range(1));
        r.is_imported = 1'b0;
        r.key         = $urandom;
        r.last        = $urandom;
        roll          = $urandom_range(99);
        if (roll < 4) begin
            r.first       = afal_pkg::UNUSED_PASS;
            r.is_imported = 1'($urandom_range(1));
        end else if (roll < 10) begin
            r.is_imported = 1'b1;
            r.first       = $urandom_range(1) ? pass_clock : $urandom;
        end else if (roll < 18) begin
            // A random key almost never matches a table key, so these rarely spoil live slots.
            r.is_imported = 1'($urandom_range(1));
            r.first       = $urandom;
        end else begin
            pass_clock = pass_clock + $urandom_range(2);
            r.key      = pool_key(r.is_image, $urandom_range(r.is_image ? 11 : 15));
            r.first    = pass_clock;
            if ($urandom_range(99) < 5)
                r.first = pass_clock - $urandom_range(4);
            r.last = r.first + $urandom_range(6);
        end
        return r;
    endfunction

    task automatic random_burst(int unsigned count);
        request_t    r;
        int unsigned done;
        done = 0;
        while (done < count) begin
            r = random_request();
            send_word(r);
            if (r.first != afal_pkg::UNUSED_PASS) done++;
        end
    endtask

    task automatic run_directed();
        int unsigned j;
        offer(16'h0000, 0, 0, pool_key(0, 0), 32'd0, 32'd0);
        offer(16'h0001, 0, 0, pool_key(0, 0), afal_pkg::UNUSED_PASS, 32'd9);
        offer(16'h0002, 1, 1, pool_key(1, 1), afal_pkg::UNUSED_PASS, 32'd9);
        offer(16'hFFFF, 1, 1, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF);
        // Last use equal to the first pass does not free the slot.
        offer(16'h0004, 0, 0, pool_key(0, 0), 32'd0, 32'd3);
        offer(16'h0005, 0, 0, pool_key(0, 0), 32'd1, 32'd4);
        offer(16'h0006, 1, 0, pool_key(1, 0), 32'd2, 32'd2);
        offer(16'h0007, 1, 0, pool_key(1, 1), 32'd3, 32'd9);
        offer(16'h0008, 1, 0, pool_key(1, 0), 32'd3, 32'd7);
        for (j = 1; j < 15; j++)
            offer(16'(16'h0100 + j), 0, 0, pool_key(0, j), 32'd5, 32'd5);
        offer(16'h0200, 0, 0, pool_key(0, 15), 32'd6, 32'd8);
        // Both slots of the first key are free here; the lower one must win.
        offer(16'h0201, 0, 0, pool_key(0, 0), 32'd10, 32'd12);
    endtask

    initial begin
        int unsigned ph;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_drained();
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_request  = 1;
                end
                1: begin
                    send_idle_pct = 80;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 80;
                end
                default: begin
                    send_idle_pct = 27;
                    stall_pct     = 27;
                end
            endcase
            random_burst(PHASE_ITEMS);
            if (ph == 1) wait_drained();
        end
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (POOL_SLOTS + 24) @(posedge aclk);
        if (sb.owed.size() != 0) begin
            $display("%0d expected words never arrived.", sb.owed.size());
            sb.failures++;
        end
        $display("Sent %0d requests, checked %0d answers: %0d reused, %0d new,",
                 sb.requests, sb.answered, sb.by_status[afal_pkg::STATUS_REUSED],
                 sb.by_status[afal_pkg::STATUS_NEW]);
        $display("%0d imported, %0d full.", sb.by_status[afal_pkg::STATUS_IMPORTED],
                 sb.by_status[afal_pkg::STATUS_FULL]);
        $display("Traffic ran free, sparse, stalled, mixed and held off once; %0d failures.",
                 sb.failures);
        if (sb.failures == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

[sim.f]
sv/afal_pkg.sv
sv/afal_pool_mem.sv
sv/afal_ctrl.sv
sv/lifetime_aliasing_pool_allocator.sv
bench/tb.sv
